@@ rtl/core/tts_pkg.sv @@
// Shared types and codes for the timed takeover sequencer.
// Used by tts_step and timed_takeover_sequencer; depends on nothing.
`timescale 1ns / 1ps

package tts_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	// event codes, carried on s_tuser
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_CANCEL = 3'd2;
	localparam logic [2:0] CMD_LINK = 3'd3;
	localparam logic [2:0] CMD_ROLE = 3'd4;

	// phases
	localparam logic [2:0] PH_INACTIVE = 3'd0;
	localparam logic [2:0] PH_PRESSED = 3'd1;
	localparam logic [2:0] PH_INITIATING = 3'd2;
	localparam logic [2:0] PH_WAITING = 3'd3;
	localparam logic [2:0] PH_COMPLETE = 3'd4;
	localparam logic [2:0] PH_FAILED = 3'd5;
	localparam logic [2:0] PH_OVERRIDE = 3'd6;

	// result codes
	localparam logic [2:0] RC_SUCCESS = 3'd0;
	localparam logic [2:0] RC_NETWORK = 3'd1;
	localparam logic [2:0] RC_LINK = 3'd2;
	localparam logic [2:0] RC_TIMEOUT = 3'd3;
	localparam logic [2:0] RC_CANCEL = 3'd4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_OVERALL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD = 2'd3;

	localparam logic [CFG_W-1:0] RST_OVERALL = 16'd10000;
	localparam logic [CFG_W-1:0] RST_SETTLE = 16'd500;
	localparam logic [CFG_W-1:0] RST_SYNC = 16'd5000;
	localparam logic [CFG_W-1:0] RST_HOLD = 16'd2000;

	typedef struct packed {
		logic [2:0] cmd;
		logic       link_here;
		logic       link_in_network;
		logic       role_is_root;
		logic       new_role_is_root;
	} ev_t;

	typedef struct packed {
		logic [2:0] phase;
		logic       running;
		logic       awaiting;
	} ctl_t;

	typedef struct packed {
		logic [CFG_W-1:0] overall_timeout_ms;
		logic [CFG_W-1:0] settle_delay_ms;
		logic [CFG_W-1:0] sync_timeout_ms;
		logic [CFG_W-1:0] display_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [2:0] state_now;
		logic       state_changed;
		logic       override_flashed;
		logic       done_res;
		logic [2:0] result_code;
		logic       claim_request;
	} res_t;

endpackage

@@ rtl/core/timed_takeover_sequencer.sv @@
// Top level of the timed takeover sequencer: input register, state, result register.
// Depends on tts_pkg and tts_step.
//
//  port group   dir   handshake          content
//  s_*          in    s_tvalid/s_tready  one event item
//  m_*          out   m_tvalid/m_tready  one result item per event
//  cfg_*        in    cfg_we             register write, no read-back
//
// One item per clock while the output is free; the result is registered the cycle after accept.
// The event logic runs in one pass from the input register into the state and
// result registers, so an item may follow in the very next cycle.
// A stalled m_tready holds the result register; the input register still takes
// one more item, then s_tready drops until the result is taken.
// Reset puts the phase to inactive, clears timers and flags, loads register defaults.
`timescale 1ns / 1ps

module timed_takeover_sequencer #(
	parameter int TIMER_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // link_here, link_in_network,
	                                                     // role_is_root, new_role_is_root, zeros
	input  logic [2:0]                        s_tuser,   // cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,   // state_now[2:0], state_changed,
	                                                     // override_flashed, done_res,
	                                                     // result_code[2:0], claim_request, zeros
	input  logic                              cfg_we,
	input  logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tts_pkg::CFG_W-1:0]         cfg_wdata
);

	tts_pkg::cfg_t         cfg_q;
	tts_pkg::ev_t          item_s1;
	logic                  vld_s1;
	tts_pkg::ctl_t         ctl_q;
	tts_pkg::ctl_t         ctl_nxt;
	logic [TIMER_BITS-1:0] phase_ms_q;
	logic [TIMER_BITS-1:0] overall_ms_q;
	logic [TIMER_BITS-1:0] phase_ms_nxt;
	logic [TIMER_BITS-1:0] overall_ms_nxt;
	tts_pkg::res_t         res;
	tts_pkg::res_t         res_q;
	logic                  out_vld_q;
	logic                  adv;
	logic                  fire;

	assign adv = !out_vld_q || m_tready;
	assign fire = vld_s1 && adv;
	assign s_tready = !vld_s1 || adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overall_timeout_ms <= tts_pkg::RST_OVERALL;
			cfg_q.settle_delay_ms <= tts_pkg::RST_SETTLE;
			cfg_q.sync_timeout_ms <= tts_pkg::RST_SYNC;
			cfg_q.display_hold_ms <= tts_pkg::RST_HOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tts_pkg::CFG_OVERALL: cfg_q.overall_timeout_ms <= cfg_wdata;
				tts_pkg::CFG_SETTLE:  cfg_q.settle_delay_ms <= cfg_wdata;
				tts_pkg::CFG_SYNC:    cfg_q.sync_timeout_ms <= cfg_wdata;
				tts_pkg::CFG_HOLD:    cfg_q.display_hold_ms <= cfg_wdata;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd <= s_tuser;
			item_s1.link_here <= s_tdata[0];
			item_s1.link_in_network <= s_tdata[1];
			item_s1.role_is_root <= s_tdata[2];
			item_s1.new_role_is_root <= s_tdata[3];
		end
	end

	tts_step #(
		.TIMER_BITS(TIMER_BITS)
	) u_step (
		.ctl            (ctl_q),
		.phase_ms       (phase_ms_q),
		.overall_ms     (overall_ms_q),
		.ev             (item_s1),
		.cfg            (cfg_q),
		.ctl_nxt        (ctl_nxt),
		.phase_ms_nxt   (phase_ms_nxt),
		.overall_ms_nxt (overall_ms_nxt),
		.res            (res)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.phase <= tts_pkg::PH_INACTIVE;
			ctl_q.running <= 1'b0;
			ctl_q.awaiting <= 1'b0;
			phase_ms_q <= '0;
			overall_ms_q <= '0;
		end else if (fire) begin
			ctl_q <= ctl_nxt;
			phase_ms_q <= phase_ms_nxt;
			overall_ms_q <= overall_ms_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = {6'd0, res_q.claim_request, res_q.result_code, res_q.done_res,
		res_q.override_flashed, res_q.state_changed, res_q.state_now};

	// a claim only goes out on the move into waiting
	a_claim_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.claim_request |-> ctl_nxt.phase == tts_pkg::PH_WAITING && ctl_nxt.awaiting)
		else $error("claim request outside waiting");

	// link refusal always lands in failed with the link code
	a_flash_failed: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.override_flashed |-> res.done_res && res.state_changed
		&& res.result_code == tts_pkg::RC_LINK && ctl_nxt.phase == tts_pkg::PH_FAILED)
		else $error("override flash without link failure");

	// a completion leaves nothing awaiting
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done_res |=> !ctl_q.awaiting)
		else $error("awaiting still set after completion");

	// inactive carries no running attempt
	a_inactive_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase == tts_pkg::PH_INACTIVE |-> !ctl_q.running && !ctl_q.awaiting
		&& phase_ms_q == '0)
		else $error("inactive with live attempt state");

endmodule

@@ rtl/core/tts_step.sv @@
// Next-state and result logic for one event of the takeover sequencer.
// Pure combinational; uses tts_pkg types and codes.
`timescale 1ns / 1ps

module tts_step #(
	parameter int TIMER_BITS = 16
) (
	input  tts_pkg::ctl_t          ctl,
	input  logic [TIMER_BITS-1:0]  phase_ms,
	input  logic [TIMER_BITS-1:0]  overall_ms,
	input  tts_pkg::ev_t           ev,
	input  tts_pkg::cfg_t          cfg,
	output tts_pkg::ctl_t          ctl_nxt,
	output logic [TIMER_BITS-1:0]  phase_ms_nxt,
	output logic [TIMER_BITS-1:0]  overall_ms_nxt,
	output tts_pkg::res_t          res
);

	localparam int CMP_W = (TIMER_BITS > tts_pkg::CFG_W) ? TIMER_BITS : tts_pkg::CFG_W;
	localparam logic [TIMER_BITS-1:0] T_MAX = {TIMER_BITS{1'b1}};

	logic [TIMER_BITS-1:0] pm_inc;
	logic [TIMER_BITS-1:0] om_inc;
	logic [CMP_W-1:0]      pm_ext;
	logic [CMP_W-1:0]      om_ext;
	logic                  ge_overall;
	logic                  ge_settle;
	logic                  ge_sync;
	logic                  ge_hold;
	logic                  busy;
	logic                  go;
	logic [2:0]            tgt;

	// saturating timers
	assign pm_inc = (phase_ms == T_MAX) ? phase_ms : phase_ms + TIMER_BITS'(1);
	assign om_inc = (overall_ms == T_MAX) ? overall_ms : overall_ms + TIMER_BITS'(1);
	assign pm_ext = CMP_W'(pm_inc);
	assign om_ext = CMP_W'(om_inc);

	assign ge_overall = om_ext >= CMP_W'(cfg.overall_timeout_ms);
	assign ge_settle  = pm_ext >= CMP_W'(cfg.settle_delay_ms);
	assign ge_sync    = pm_ext >= CMP_W'(cfg.sync_timeout_ms);
	assign ge_hold    = pm_ext >= CMP_W'(cfg.display_hold_ms);

	assign busy = (ctl.phase == tts_pkg::PH_PRESSED) || (ctl.phase == tts_pkg::PH_INITIATING)
		|| (ctl.phase == tts_pkg::PH_WAITING);

	always_comb begin
		ctl_nxt = ctl;
		phase_ms_nxt = phase_ms;
		overall_ms_nxt = overall_ms;
		res = '0;
		go = 1'b0;
		tgt = ctl.phase;

		case (ev.cmd)
			tts_pkg::CMD_TICK: begin
				if (ctl.phase != tts_pkg::PH_INACTIVE) begin
					phase_ms_nxt = pm_inc;
					overall_ms_nxt = om_inc;
					if (busy && ctl.running && ge_overall) begin
						go = 1'b1;
						tgt = tts_pkg::PH_FAILED;
						ctl_nxt.awaiting = 1'b0;
						res.done_res = 1'b1;
						res.result_code = tts_pkg::RC_TIMEOUT;
					end else begin
						unique case (ctl.phase)
							tts_pkg::PH_PRESSED: begin
								if (ge_settle) begin
									go = 1'b1;
									tgt = tts_pkg::PH_INITIATING;
								end
							end
							tts_pkg::PH_INITIATING: begin
								go = 1'b1;
								if (ev.role_is_root) begin
									// already root: straight to complete, no claim
									tgt = tts_pkg::PH_COMPLETE;
									ctl_nxt.awaiting = 1'b0;
									res.done_res = 1'b1;
									res.result_code = tts_pkg::RC_SUCCESS;
								end else begin
									tgt = tts_pkg::PH_WAITING;
									ctl_nxt.awaiting = 1'b1;
									res.claim_request = 1'b1;
								end
							end
							tts_pkg::PH_WAITING: begin
								if (ctl.awaiting) begin
									if (ge_sync) begin
										go = 1'b1;
										tgt = tts_pkg::PH_FAILED;
										ctl_nxt.awaiting = 1'b0;
										res.done_res = 1'b1;
										res.result_code = tts_pkg::RC_NETWORK;
									end
								end else if (ev.role_is_root) begin
									go = 1'b1;
									tgt = tts_pkg::PH_COMPLETE;
									ctl_nxt.awaiting = 1'b0;
									res.done_res = 1'b1;
									res.result_code = tts_pkg::RC_SUCCESS;
								end
							end
							default: begin
								// terminal phases: hold for display, then back to inactive
								if (ge_hold) begin
									go = 1'b1;
									tgt = tts_pkg::PH_INACTIVE;
								end
							end
						endcase
					end
				end
			end
			tts_pkg::CMD_START: begin
				if (ctl.phase == tts_pkg::PH_INACTIVE) begin
					go = 1'b1;
					if (ev.link_here || ev.link_in_network) begin
						// flags an override flash on the way to failed
						tgt = tts_pkg::PH_FAILED;
						ctl_nxt.awaiting = 1'b0;
						res.done_res = 1'b1;
						res.result_code = tts_pkg::RC_LINK;
						res.override_flashed = 1'b1;
					end else begin
						tgt = tts_pkg::PH_PRESSED;
						overall_ms_nxt = '0;
						ctl_nxt.running = 1'b1;
					end
				end
			end
			tts_pkg::CMD_CANCEL: begin
				if (ctl.phase != tts_pkg::PH_INACTIVE) begin
					go = 1'b1;
					tgt = tts_pkg::PH_FAILED;
					ctl_nxt.awaiting = 1'b0;
					res.done_res = 1'b1;
					res.result_code = tts_pkg::RC_CANCEL;
				end
			end
			tts_pkg::CMD_LINK: begin
				if (busy) begin
					go = 1'b1;
					tgt = tts_pkg::PH_FAILED;
					ctl_nxt.awaiting = 1'b0;
					res.done_res = 1'b1;
					res.result_code = tts_pkg::RC_LINK;
					res.override_flashed = 1'b1;
				end
			end
			tts_pkg::CMD_ROLE: begin
				if (ctl.awaiting) begin
					ctl_nxt.awaiting = 1'b0;
					if (ctl.phase == tts_pkg::PH_WAITING) begin
						go = 1'b1;
						res.done_res = 1'b1;
						if (ev.new_role_is_root) begin
							tgt = tts_pkg::PH_COMPLETE;
							res.result_code = tts_pkg::RC_SUCCESS;
						end else begin
							tgt = tts_pkg::PH_FAILED;
							res.result_code = tts_pkg::RC_NETWORK;
						end
					end
				end
			end
			default: ;
		endcase

		// phase change: clear phase timer; entering inactive clears the rest
		if (go && (tgt != ctl.phase)) begin
			ctl_nxt.phase = tgt;
			phase_ms_nxt = '0;
			res.state_changed = 1'b1;
			if (tgt == tts_pkg::PH_INACTIVE) begin
				overall_ms_nxt = '0;
				ctl_nxt.running = 1'b0;
				ctl_nxt.awaiting = 1'b0;
			end
		end
		res.state_now = ctl_nxt.phase;
	end

endmodule
